>>> rtl/lms_adaptive_fir_filter_macros.svh
// ----------------------------------------------------------------------------
// lms adaptive fir filter assertion macros
// concurrent assertion shorthands used by the port checker
// ----------------------------------------------------------------------------
`ifndef LMS_ADAPTIVE_FIR_FILTER_MACROS_SVH
`define LMS_ADAPTIVE_FIR_FILTER_MACROS_SVH

// same-cycle implication, disabled during reset
`define LMSF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lmsf assertion failed");

// next-cycle implication, disabled during reset
`define LMSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lmsf assertion failed");

`endif

>>> rtl/lmsf_pkg.sv
// ----------------------------------------------------------------------------
// lmsf_pkg
// shared widths, constants, types and saturation helpers of the lms filter
// ----------------------------------------------------------------------------
`default_nettype none

package lmsf_pkg;

    localparam int TAPS_DEF   = 64;

    localparam int SMP_W      = 16;    // q1.15 samples
    localparam int WGT_W      = 24;    // q2.22 weights
    localparam int STEP_W     = 24;    // q0.24 step size
    localparam int SE_W       = STEP_W + 1 + SMP_W;  // step * error
    localparam int UPD_W      = SE_W + SMP_W;        // step * error * sample
    localparam int PROD_W     = WGT_W + SMP_W;       // weight * sample

    localparam logic [STEP_W-1:0] STEP_RESET = 24'd131072;

    localparam int S_MAX      = 32767;
    localparam int S_MIN      = -32768;

    // one tap of the delay line and its weight
    typedef struct packed {
        logic signed [WGT_W-1:0] w;    // weight
        logic signed [SMP_W-1:0] x;    // current delayed sample
        logic signed [SMP_W-1:0] xo;   // sample held here before the last shift
    } t_tap;

    typedef struct packed {
        logic shift;    // new sample enters, delay line moves one tap
        logic rotate;   // whole chain moves one cell toward the head
    } t_cell_ctl;

    function automatic logic signed [WGT_W-1:0] sat_wgt(input logic signed [WGT_W+2:0] v);
        if (v > 27'sd8388607) begin
            return 24'sh7FFFFF;
        end else if (v < -27'sd8388608) begin
            return 24'sh800000;
        end else begin
            return v[WGT_W-1:0];
        end
    endfunction

    function automatic logic signed [SMP_W-1:0] sat_smp(input logic signed [SMP_W:0] v);
        if (v > 17'sd32767) begin
            return 16'sh7FFF;
        end else if (v < -17'sd32768) begin
            return 16'sh8000;
        end else begin
            return v[SMP_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/lmsf_if.sv
// ----------------------------------------------------------------------------
// lmsf channel interfaces
// valid/ready channels for sample items and result items
// ----------------------------------------------------------------------------
`default_nettype none

interface lmsf_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [lmsf_pkg::SMP_W-1:0]   signal_sample;
    logic signed [lmsf_pkg::SMP_W-1:0]   desired_sample;

    modport source (output valid, output signal_sample, output desired_sample, input ready);
    modport sink   (input valid, input signal_sample, input desired_sample, output ready);
endinterface

interface lmsf_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [lmsf_pkg::SMP_W-1:0]   filter_output;
    logic signed [lmsf_pkg::SMP_W-1:0]   error_value;

    modport source (output valid, output filter_output, output error_value, input ready);
    modport sink   (input valid, input filter_output, input error_value, output ready);
endinterface

`default_nettype wire

>>> rtl/lms_adaptive_fir_filter.sv
// ----------------------------------------------------------------------------
// lms_adaptive_fir_filter
// least-mean-squares adaptive fir filter built as a rotating chain of tap cells
// ----------------------------------------------------------------------------
// Each input item carries one q1.15 signal sample and one q1.15 desired
// sample and produces exactly one result item: the filter output (formed with
// the weights before this item's update, rounded half up and saturated) and
// the error desired minus output (saturated). The taps live in a chain of
// TAPS cells, each holding a q2.22 weight, its delayed sample and the sample it
// held before the latest shift. A single shared unit sits between the head and
// the tail of the chain: as the chain rotates once, every weight first takes
// the pending update of the previous item (step * error * old sample) and the
// updated weight is then multiplied with the current sample and accumulated.
// After an item is accepted, its sample shifts in at the accepting edge, the
// chain rotates once through the two-stage update loop, and the drain, output
// rounding, error and step*error states follow. The result then moves into the
// output register once that register is free or being emptied, and only then
// is a new item accepted, even if the previous result has not been taken yet.
// The step size is written through the configuration channel, which is always
// ready, and must only change while no item is in flight; the value in force
// when an item finishes is the one used for that item's weight update.
// ----------------------------------------------------------------------------
`default_nettype none

module lms_adaptive_fir_filter #(
    parameter int TAPS = lmsf_pkg::TAPS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    lmsf_in_if.sink                                   i_in,
    lmsf_out_if.source                                o_out,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [lmsf_pkg::STEP_W-1:0]          i_cfg_step_size
);

    localparam int ACC_W = lmsf_pkg::PROD_W + $clog2(TAPS);
    localparam int Q_W   = ACC_W + 1 - 22;
    localparam int CNT_W = $clog2(TAPS + 2);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TAPS + 1);
    localparam logic [CNT_W-1:0] CNT_LIVE = CNT_W'(TAPS);
    localparam logic signed [Q_W-1:0] Q_HI = Q_W'(lmsf_pkg::S_MAX);
    localparam logic signed [Q_W-1:0] Q_LO = Q_W'(lmsf_pkg::S_MIN);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,   // waiting for an item
        ST_RUN   = 6'b000010,   // chain rotating through the mac
        ST_DRAIN = 6'b000100,   // last product lands in the accumulator
        ST_YOUT  = 6'b001000,   // round and saturate the output
        ST_ERR   = 6'b010000,   // error = desired - output
        ST_UPD   = 6'b100000    // step * error, hand result to output register
    } t_state;

    t_state                                r_state, n_state;
    logic [CNT_W-1:0]                      r_cnt;
    logic [lmsf_pkg::STEP_W-1:0]           r_step;
    logic signed [lmsf_pkg::SMP_W-1:0]     r_d;
    logic signed [lmsf_pkg::SMP_W-1:0]     r_y;
    logic signed [lmsf_pkg::SMP_W-1:0]     r_e;
    logic signed [lmsf_pkg::SE_W-1:0]      r_se;     // pending update gain for the next pass
    logic                                  r_out_valid;
    logic signed [lmsf_pkg::SMP_W-1:0]     r_out_y;
    logic signed [lmsf_pkg::SMP_W-1:0]     r_out_e;

    logic                                  w_accept;
    logic                                  w_load;
    logic                                  w_live;
    lmsf_pkg::t_cell_ctl                   w_ctl;
    lmsf_pkg::t_tap                        w_tap   [TAPS];
    lmsf_pkg::t_tap                        w_right [TAPS];
    logic signed [lmsf_pkg::SMP_W-1:0]     w_left  [TAPS];
    lmsf_pkg::t_tap                        w_tail;
    logic signed [ACC_W-1:0]               w_acc;
    logic signed [ACC_W:0]                 w_acc_rnd;
    logic signed [Q_W-1:0]                 w_q;
    logic signed [lmsf_pkg::SMP_W-1:0]     w_y_sat;
    logic signed [lmsf_pkg::SMP_W:0]       w_diff;

    // handshakes
    assign i_in.ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;
    // result moves out only when the output register is free or being emptied
    assign w_load      = (r_state == ST_UPD) && (!r_out_valid || o_out.ready);
    assign o_cfg_ready = 1'b1;

    // only rotation steps while the counter is below TAPS put real taps into the mac
    assign w_live       = (r_state == ST_RUN) && (r_cnt < CNT_LIVE);
    assign w_ctl.shift  = w_accept;
    assign w_ctl.rotate = (r_state == ST_RUN);

    // chain of tap cells: newest sample enters at cell 0, rotation moves
    // every cell toward the head and the mac output re-enters at the tail
    for (genvar g = 0; g < TAPS; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_left[g] = i_in.signal_sample;
        end else begin : g_inner
            assign w_left[g] = w_tap[g-1].x;
        end
        if (g == TAPS - 1) begin : g_last
            assign w_right[g] = w_tail;
        end else begin : g_body
            assign w_right[g] = w_tap[g+1];
        end

        lmsf_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (w_ctl),
            .i_left_x (w_left[g]),
            .i_right  (w_right[g]),
            .o_tap    (w_tap[g])
        );
    end

    lmsf_mac #(
        .TAPS (TAPS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_accept),
        .i_live  (w_live),
        .i_head  (w_tap[0]),
        .i_se    (r_se),
        .o_tail  (w_tail),
        .o_acc   (w_acc)
    );

    // output rounding: add half an lsb of q1.15, drop 22 bits, saturate
    always_comb begin
        w_acc_rnd = {w_acc[ACC_W-1], w_acc} + (ACC_W+1)'(1 << 21);
        w_q       = w_acc_rnd[ACC_W:22];
        if (w_q > Q_HI) begin
            w_y_sat = 16'sh7FFF;
        end else if (w_q < Q_LO) begin
            w_y_sat = 16'sh8000;
        end else begin
            w_y_sat = w_q[lmsf_pkg::SMP_W-1:0];
        end
        w_diff = {r_d[lmsf_pkg::SMP_W-1], r_d} - {r_y[lmsf_pkg::SMP_W-1], r_y};
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_YOUT;
            ST_YOUT:  n_state = ST_ERR;
            ST_ERR:   n_state = ST_UPD;
            ST_UPD: begin
                if (w_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_step      <= lmsf_pkg::STEP_RESET;
            r_se        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_cnt <= '0;
            end else if (r_state == ST_RUN) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cfg_valid) begin
                r_step <= i_cfg_step_size;
            end
            // gain for the weight update folded into the next pass
            if (r_state == ST_UPD) begin
                r_se <= $signed({1'b0, r_step}) * r_e;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_d <= i_in.desired_sample;
        end
        if (r_state == ST_YOUT) begin
            r_y <= w_y_sat;
        end
        if (r_state == ST_ERR) begin
            r_e <= lmsf_pkg::sat_smp(w_diff);
        end
        if (w_load) begin
            r_out_y <= r_y;
            r_out_e <= r_e;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.filter_output = r_out_y;
    assign o_out.error_value   = r_out_e;

endmodule

`default_nettype wire

>>> rtl/lmsf_cell.sv
// ----------------------------------------------------------------------------
// lmsf_cell
// one tap: weight, delayed sample and previous sample, shifts or rotates
// ----------------------------------------------------------------------------
`default_nettype none

module lmsf_cell (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire lmsf_pkg::t_cell_ctl               i_ctl,
    input  wire logic signed [lmsf_pkg::SMP_W-1:0] i_left_x,
    input  wire lmsf_pkg::t_tap                    i_right,
    output lmsf_pkg::t_tap                         o_tap
);

    lmsf_pkg::t_tap r_tap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap <= '0;
        end else if (i_ctl.rotate) begin
            r_tap <= i_right;
        end else if (i_ctl.shift) begin
            r_tap.xo <= r_tap.x;
            r_tap.x  <= i_left_x;
        end
    end

    assign o_tap = r_tap;

endmodule

`default_nettype wire

>>> rtl/lmsf_mac.sv
// ----------------------------------------------------------------------------
// lmsf_mac
// shared update and multiply-accumulate unit at the head of the cell chain
// ----------------------------------------------------------------------------
`default_nettype none

module lmsf_mac #(
    parameter int TAPS = lmsf_pkg::TAPS_DEF
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire logic                                          i_clear,
    input  wire logic                                          i_live,
    input  wire lmsf_pkg::t_tap                                i_head,
    input  wire logic signed [lmsf_pkg::SE_W-1:0]              i_se,
    output lmsf_pkg::t_tap                                     o_tail,
    output logic signed [lmsf_pkg::PROD_W+$clog2(TAPS)-1:0]    o_acc
);

    localparam int ACC_W = lmsf_pkg::PROD_W + $clog2(TAPS);
    localparam int RND_W = lmsf_pkg::UPD_W + 1;
    localparam int DLT_W = RND_W - 32;

    // stage 1: step * error * old sample
    lmsf_pkg::t_tap                           r_s1_tap;
    logic signed [lmsf_pkg::UPD_W-1:0]        r_s1_upd;
    logic                                     r_v1;
    // stage 2: updated weight
    lmsf_pkg::t_tap                           r_s2_tap;
    logic                                     r_v2;
    // stage 3: weight * sample
    logic signed [lmsf_pkg::PROD_W-1:0]       r_s3_prod;
    logic                                     r_v3;
    logic signed [ACC_W-1:0]                  r_acc;

    logic signed [RND_W-1:0]                  w_rnd;
    logic signed [DLT_W-1:0]                  w_delta;
    logic signed [lmsf_pkg::WGT_W+2:0]        w_wsum;
    lmsf_pkg::t_tap                           n_s2_tap;

    // round half up to q.22, then saturating add onto the weight
    always_comb begin
        w_rnd    = {r_s1_upd[lmsf_pkg::UPD_W-1], r_s1_upd} + (RND_W'(1) <<< 31);
        w_delta  = w_rnd[RND_W-1:32];
        w_wsum   = {{3{r_s1_tap.w[lmsf_pkg::WGT_W-1]}}, r_s1_tap.w}
                 + (lmsf_pkg::WGT_W+3)'(w_delta);
        n_s2_tap      = r_s1_tap;
        n_s2_tap.w    = lmsf_pkg::sat_wgt(w_wsum);
    end

    always_ff @(posedge i_clk) begin
        r_s1_tap  <= i_head;
        r_s1_upd  <= i_se * $signed(i_head.xo);
        r_s2_tap  <= n_s2_tap;
        r_s3_prod <= $signed(r_s2_tap.w) * $signed(r_s2_tap.x);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_acc <= '0;
        end else begin
            r_v1 <= i_live;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (i_clear) begin
                r_acc <= '0;
            end else if (r_v3) begin
                r_acc <= r_acc + ACC_W'(r_s3_prod);
            end
        end
    end

    assign o_tail = r_s2_tap;
    assign o_acc  = r_acc;

endmodule

`default_nettype wire

>>> rtl/lmsf_checker.sv
// ----------------------------------------------------------------------------
// lmsf_checker
// port-level checks of the lms filter, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "lms_adaptive_fir_filter_macros.svh"

module lmsf_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    input  wire logic                              i_in_ready,
    input  wire logic                              i_out_valid,
    input  wire logic                              i_out_ready,
    input  wire logic signed [lmsf_pkg::SMP_W-1:0] i_filter_output,
    input  wire logic signed [lmsf_pkg::SMP_W-1:0] i_error_value
);

    // a waiting result stays offered
    `LMSF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    // and keeps its value
    `LMSF_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_filter_output) && $stable(i_error_value))
    // one item at a time: busy right after an accept
    `LMSF_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)
    // a result never follows its item in the very next cycle
    `LMSF_ASSERT_NEXT(a_no_early, i_clk, i_rst_n, i_in_valid && i_in_ready, !$rose(i_out_valid))
    // a fresh result means the filter is free again
    `LMSF_ASSERT_NOW(a_free_after, i_clk, i_rst_n, $rose(i_out_valid), i_in_ready)

endmodule

bind lms_adaptive_fir_filter lmsf_checker u_lmsf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_filter_output (o_out.filter_output),
    .i_error_value   (o_out.error_value)
);

`default_nettype wire
